// ===== sv/cpfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfr_pkg: shared types and constants of the tachometer period-to-rpm block
// Field widths, register codes, reset values and the result record.
// ----------------------------------------------------------------------------
package cpfr_pkg;

  localparam int unsigned CapW     = 16;
  localparam int unsigned NumW     = 32;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned StepCntW = $clog2(QuoW);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned OutDataW = 80;

  localparam logic [NumW-1:0] FreqNumReset = 32'd4000000;
  localparam logic [NumW-1:0] RpmNumReset  = 32'd60000000;
  localparam logic [QuoW-1:0] SatQuotient  = 32'hFFFF_FFFF;
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(QuoW - 1);

  typedef enum logic [CfgIdxW-1:0] {
    RegFreqNum = 1'b0,
    RegRpmNum  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    DivIdle,
    DivRun
  } div_state_e;

  // Period handed from the front end to the queue
  typedef struct packed {
    logic            valid;
    logic [CapW-1:0] period;
  } push_t;

  typedef struct packed {
    logic [QuoW-1:0] rpm;
    logic [QuoW-1:0] freq;
    logic [CapW-1:0] period;
  } result_t;

endpackage

// ===== sv/cpfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfr_front: capture intake
// Accepts captures, forms the wrapped period and keeps the previous capture.
// ----------------------------------------------------------------------------
module cpfr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cpfr_pkg::CapW-1:0]     s_axis_tdata,  // [15:0] capture_time
  input  logic                          queue_full_i,
  output cpfr_pkg::push_t               push_o
);

  logic [cpfr_pkg::CapW-1:0] last_capture_q, last_capture_d;
  logic                      accept;

  assign s_axis_tready = !queue_full_i;
  assign accept        = s_axis_tvalid && !queue_full_i;

  always_comb begin
    last_capture_d = accept ? s_axis_tdata : last_capture_q;
    push_o.valid   = accept;
    // modulo 2^16 by construction
    push_o.period  = s_axis_tdata - last_capture_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_capture_q <= '0;
    end else begin
      last_capture_q <= last_capture_d;
    end
  end

endmodule

// ===== sv/cpfr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfr_queue: two-entry period queue
// Decouples capture intake from the divider.
// ----------------------------------------------------------------------------
module cpfr_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpfr_pkg::push_t           push_i,
  output logic                      full_o,
  output logic                      not_empty_o,
  output logic [cpfr_pkg::CapW-1:0] head_o,
  input  logic                      pop_i
);

  logic [cpfr_pkg::CapW-1:0] entry_q [2];
  logic                      wr_ptr_q, wr_ptr_d;
  logic                      rd_ptr_q, rd_ptr_d;
  logic [1:0]                count_q, count_d;
  logic                      do_pop;

  assign full_o      = (count_q == 2'd2);
  assign not_empty_o = (count_q != 2'd0);
  assign head_o      = entry_q[rd_ptr_q];
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = push_i.valid ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i.valid} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.period;
    end
  end

endmodule

// ===== sv/cpfr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpfr_div: dual restoring divider with output register
// Divides both numerators by the period, one quotient bit per cycle; the last bit waits for a free output register.
// ----------------------------------------------------------------------------
module cpfr_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_not_empty_i,
  input  logic [cpfr_pkg::CapW-1:0]    q_head_i,
  output logic                         q_pop_o,
  input  logic [cpfr_pkg::NumW-1:0]    freq_num_i,
  input  logic [cpfr_pkg::NumW-1:0]    rpm_num_i,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cpfr_pkg::OutDataW-1:0] m_axis_tdata,  // [15:0] period_ticks,
                                                       // [47:16] frequency,
                                                       // [79:48] speed_rpm
  output logic                         m_axis_tuser   // [0] zero_period
);

  cpfr_pkg::div_state_e state_q, state_d;

  logic [cpfr_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic [cpfr_pkg::CapW-1:0]     den_q, den_d;
  logic [cpfr_pkg::QuoW-1:0]     num_f_q, num_f_d, num_r_q, num_r_d;
  logic [cpfr_pkg::CapW-1:0]     rem_f_q, rem_f_d, rem_r_q, rem_r_d;

  logic                          out_valid_q, out_valid_d;
  cpfr_pkg::result_t             out_res_q, out_res_d;
  logic                          out_zero_q, out_zero_d;
  logic                          out_load;

  logic [cpfr_pkg::CapW:0]       ext_f, ext_r;
  logic [cpfr_pkg::CapW+1:0]     diff_f, diff_r;
  logic                          ge_f, ge_r;
  logic [cpfr_pkg::CapW-1:0]     step_rem_f, step_rem_r;
  logic [cpfr_pkg::QuoW-1:0]     step_num_f, step_num_r;
  logic                          out_free;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_res_q.rpm, out_res_q.freq, out_res_q.period};
  assign m_axis_tuser  = out_zero_q;

  // One restoring step per lane
  always_comb begin
    ext_f      = {rem_f_q, num_f_q[cpfr_pkg::QuoW-1]};
    ext_r      = {rem_r_q, num_r_q[cpfr_pkg::QuoW-1]};
    diff_f     = {1'b0, ext_f} - {2'b00, den_q};
    diff_r     = {1'b0, ext_r} - {2'b00, den_q};
    ge_f       = !diff_f[cpfr_pkg::CapW+1];
    ge_r       = !diff_r[cpfr_pkg::CapW+1];
    step_rem_f = ge_f ? diff_f[cpfr_pkg::CapW-1:0] : ext_f[cpfr_pkg::CapW-1:0];
    step_rem_r = ge_r ? diff_r[cpfr_pkg::CapW-1:0] : ext_r[cpfr_pkg::CapW-1:0];
    step_num_f = {num_f_q[cpfr_pkg::QuoW-2:0], ge_f};
    step_num_r = {num_r_q[cpfr_pkg::QuoW-2:0], ge_r};
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    den_d      = den_q;
    num_f_d    = num_f_q;
    num_r_d    = num_r_q;
    rem_f_d    = rem_f_q;
    rem_r_d    = rem_r_q;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    out_res_d  = out_res_q;
    out_zero_d = out_zero_q;

    unique case (state_q)
      cpfr_pkg::DivIdle: begin
        if (q_not_empty_i) begin
          if (q_head_i == '0) begin
            // zero period: saturate without dividing
            if (out_free) begin
              q_pop_o          = 1'b1;
              out_load         = 1'b1;
              out_res_d.period = q_head_i;
              out_res_d.freq   = cpfr_pkg::SatQuotient;
              out_res_d.rpm    = cpfr_pkg::SatQuotient;
              out_zero_d       = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            den_d   = q_head_i;
            num_f_d = freq_num_i;
            num_r_d = rpm_num_i;
            rem_f_d = '0;
            rem_r_d = '0;
            cnt_d   = '0;
            state_d = cpfr_pkg::DivRun;
          end
        end
      end
      cpfr_pkg::DivRun: begin
        if (cnt_q != cpfr_pkg::LastStep) begin
          num_f_d = step_num_f;
          num_r_d = step_num_r;
          rem_f_d = step_rem_f;
          rem_r_d = step_rem_r;
          cnt_d   = cnt_q + cpfr_pkg::StepCntW'(1);
        end else if (out_free) begin
          // hold the last step until the output register frees up
          out_load         = 1'b1;
          out_res_d.period = den_q;
          out_res_d.freq   = step_num_f;
          out_res_d.rpm    = step_num_r;
          out_zero_d       = 1'b0;
          state_d          = cpfr_pkg::DivIdle;
        end
      end
      default: state_d = cpfr_pkg::DivIdle;
    endcase

    out_valid_d = out_load || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpfr_pkg::DivIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q      <= den_d;
    num_f_q    <= num_f_d;
    num_r_q    <= num_r_d;
    rem_f_q    <= rem_f_d;
    rem_r_q    <= rem_r_d;
    out_res_q  <= out_res_d;
    out_zero_q <= out_zero_d;
  end

endmodule

// ===== sv/capture_period_to_frequency_rpm_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_period_to_frequency_rpm_top: tachometer period to frequency and rpm
// Turns timer captures into period, frequency and rpm results.
// ----------------------------------------------------------------------------
// Each capture yields one result: the wrapped 16-bit period since the previous
// capture (0 after reset), and the two programmed numerators divided by that
// period. A zero period sets tuser and saturates both quotients to all ones.
// A nonzero period is loaded, taken through 31 divider steps, and its final
// step retired into the output register by the bit-serial restoring divider,
// which makes one quotient bit per cycle for both quotients, holding the last bit
// while the output register is full; a zero period bypasses division. The front end
// takes captures without waiting on the divider while the two-entry period
// queue has room, and a finished result waits in the output register.
// ----------------------------------------------------------------------------
module capture_period_to_frequency_rpm_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cpfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cpfr_pkg::NumW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cpfr_pkg::CapW-1:0]     s_axis_tdata,  // [15:0] capture_time
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cpfr_pkg::OutDataW-1:0] m_axis_tdata,  // [15:0] period_ticks,
                                                       // [47:16] frequency,
                                                       // [79:48] speed_rpm
  output logic                          m_axis_tuser   // [0] zero_period
);

  logic [cpfr_pkg::NumW-1:0] freq_num_q, freq_num_d;
  logic [cpfr_pkg::NumW-1:0] rpm_num_q, rpm_num_d;

  cpfr_pkg::push_t           push;
  logic                      queue_full;
  logic                      q_not_empty;
  logic [cpfr_pkg::CapW-1:0] q_head;
  logic                      q_pop;

  always_comb begin
    freq_num_d = freq_num_q;
    rpm_num_d  = rpm_num_q;
    if (cfg_we_i) begin
      unique case (cpfr_pkg::cfg_reg_e'(cfg_idx_i))
        cpfr_pkg::RegFreqNum: freq_num_d = cfg_data_i;
        cpfr_pkg::RegRpmNum:  rpm_num_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_num_q <= cpfr_pkg::FreqNumReset;
      rpm_num_q  <= cpfr_pkg::RpmNumReset;
    end else begin
      freq_num_q <= freq_num_d;
      rpm_num_q  <= rpm_num_d;
    end
  end

  cpfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full_i  (queue_full),
    .push_o        (push)
  );

  cpfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (queue_full),
    .not_empty_o (q_not_empty),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  cpfr_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .freq_num_i    (freq_num_q),
    .rpm_num_i     (rpm_num_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== tb/sv/capture_period_to_frequency_rpm_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_period_to_frequency_rpm_top_test: self-checking bench for the
// tachometer period-to-rpm block
// Drives timer captures over the input stream and checks period, frequency,
// rpm and the zero-period flag of every result against a predictor kept in a
// scoreboard. Numerators are reprogrammed between phases while the block is
// idle, and both stream sides idle and stall at random rates per phase.
// ----------------------------------------------------------------------------
module capture_period_to_frequency_rpm_top_test;
  import cpfr_pkg::*;

  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned RandPhases   = 8;
  localparam int unsigned RandPerPhase = 130;

  typedef enum {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    result_t data;
    logic    zero_period;
  } tach_expect_t;

  class tach_scoreboard;
    logic [NumW-1:0] freq_num     = FreqNumReset;
    logic [NumW-1:0] rpm_num      = RpmNumReset;
    logic [CapW-1:0] last_capture = '0;
    tach_expect_t    expected_q[$];
    int unsigned     errors       = 0;

    function void set_numerator(cfg_reg_e idx, logic [NumW-1:0] value);
      if (idx == RegFreqNum) begin
        freq_num = value;
      end else begin
        rpm_num = value;
      end
    endfunction

    function logic [QuoW-1:0] quotient(logic [NumW-1:0] num, logic [CapW-1:0] period);
      if (period == '0) return SatQuotient;
      return QuoW'(num / NumW'(period));
    endfunction

    function void note_capture(logic [CapW-1:0] cap);
      tach_expect_t e;
      e.data.period = cap - last_capture;
      e.data.freq   = quotient(freq_num, e.data.period);
      e.data.rpm    = quotient(rpm_num, e.data.period);
      e.zero_period = (e.data.period == '0);
      expected_q.push_back(e);
      last_capture = cap;
    endfunction

    function void compare_field(string name, logic [QuoW-1:0] exp_v, logic [QuoW-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got, logic got_zero);
      tach_expect_t e;
      if (expected_q.size() == 0) begin
        $error("result item with no capture pending");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("period_ticks", e.data.period, got.period);
      compare_field("frequency", e.data.freq, got.freq);
      compare_field("speed_rpm", e.data.rpm, got.rpm);
      compare_field("zero_period", e.zero_period, got_zero);
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [NumW-1:0]     cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [CapW-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  tach_scoreboard  sb = new();
  int unsigned     src_idle_pct   = 0;
  int unsigned     sink_stall_pct = 0;
  logic [CapW-1:0] prev_capture   = '0;

  capture_period_to_frequency_rpm_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_capture(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(result_t'(m_axis_tdata),
                                                                  m_axis_tuser);
  end

  // End the run after too long without any item moving
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("end of test: mismatches");
    $finish;
  end

  function void set_idle(idle_mode_e mode);
    src_idle_pct   = (mode == IdleSender)   ? 84 : (mode == IdleBoth) ? 8 : 0;
    sink_stall_pct = (mode == IdleReceiver) ? 84 : (mode == IdleBoth) ? 8 : 0;
  endfunction

  function automatic logic [CapW-1:0] next_capture(logic [CapW-1:0] prev);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return prev;
    if (r < 12) return prev + CapW'($urandom_range(1, 3));
    if (r < 22) return CapW'($urandom_range(65535));
    // wrap just short of a full turn: periods near the top of the range
    if (r < 30) return prev - CapW'($urandom_range(1, 16));
    return prev + CapW'($urandom_range(4, 4000));
  endfunction

  function automatic logic [NumW-1:0] pick_numerator();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '1;
    if (r < 25) return NumW'(1);
    if (r < 45) return NumW'($urandom_range(1, 100000));
    return NumW'($urandom());
  endfunction

  task automatic send_capture(input logic [CapW-1:0] cap);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cap;
    prev_capture = cap;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the input until every pending result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_numerators(input logic [NumW-1:0] freq, input logic [NumW-1:0] rpm);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegFreqNum;
    cfg_data_i <= freq;
    @(posedge clk_i);
    cfg_idx_i  <= RegRpmNum;
    cfg_data_i <= rpm;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_numerator(RegFreqNum, freq);
    sb.set_numerator(RegRpmNum, rpm);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegFreqNum;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset numerators; first capture of 0 gives a zero period against reset
    set_idle(IdleNone);
    send_capture(16'h0000);
    send_capture(16'h0001);
    send_capture(16'hFFFF);
    send_capture(16'h0000);
    send_capture(16'hFFFF);
    send_capture(16'hFFFF);
    send_capture(16'h5555);
    send_capture(16'hAAAA);
    send_capture(16'h1234);

    // Largest numerators over the smallest and largest periods
    wait_drained();
    write_numerators('1, '1);
    set_idle(IdleBoth);
    send_capture(16'h1235);
    send_capture(16'h1235);
    send_capture(16'h1234);
    send_capture(16'h1236);
    send_capture(16'h2236);

    wait_drained();
    write_numerators(NumW'(1), NumW'(1));
    send_capture(16'h2237);
    send_capture(16'h2239);
    send_capture(16'h2238);

    // Zero numerators: quotient 0 unless the period is zero
    wait_drained();
    write_numerators('0, '0);
    send_capture(16'h2239);
    send_capture(16'h2239);
    send_capture(16'h8000);

    for (int ph = 0; ph < RandPhases; ph++) begin
      wait_drained();
      if (ph == 0) begin
        write_numerators(FreqNumReset, RpmNumReset);
      end else if (ph == RandPhases - 1) begin
        write_numerators('1, '1);
      end else begin
        write_numerators(pick_numerator(), pick_numerator());
      end
      set_idle(idle_mode_e'(ph % 4));
      for (int n = 0; n < RandPerPhase; n++) begin
        send_capture(next_capture(prev_capture));
        if ($urandom_range(199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
